[design/aid_pkg.sv]
// Shared types and constants for the accelerometer inactivity detector.
// Used by aid_mag and accel_inactivity_detector; no dependencies.
package aid_pkg;

  localparam int AXIS_W   = 16;
  localparam int SUM_W    = 32;
  localparam int MAG_W    = 16;
  localparam int THR_W    = 16;
  localparam int PERIOD_W = 8;
  localparam int QUIET_W  = 16;
  localparam int BUSY_W   = 14;
  localparam int CNT_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [THR_W-1:0]    QUIET_THR_RST  = 16'd7246;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 8'd15;
  localparam logic [QUIET_W-1:0]  INACT_LIM_RST  = 16'd5000;
  localparam logic [BUSY_W-1:0]   ACT_LIM_RST    = 14'd250;
  localparam logic [MAG_W-1:0]    SEED_RST       = 16'd8234;
  localparam logic [QUIET_W-1:0]  QUIET_MAX      = '1;
  localparam logic [BUSY_W-1:0]   BUSY_MAX       = '1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUIET_THR = 3'd0,
    CFG_PERIOD    = 3'd1,
    CFG_INACT_LIM = 3'd2,
    CFG_ACT_LIM   = 3'd3,
    CFG_SEED      = 3'd4
  } cfg_idx_t;

  // Top-level control sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_UPDATE
  } ctl_state_t;

  // Magnitude unit sequencer
  typedef enum logic [1:0] {
    MG_IDLE,
    MG_SQUARE,
    MG_ROOT
  } mag_state_t;

endpackage

[design/accel_inactivity_detector.sv]
// Accelerometer inactivity detector, top level.
// From input acceptance to out_valid an item passes 16 square steps, 16 root
// steps, one handoff and one state update. The shared serial multiply and
// square-root unit takes no new item until the last one is committed; the
// next item is taken while a result still waits on the output register.
// Reset (synchronous, rst_n low) loads register defaults and clears times.
module accel_inactivity_detector
  import aid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Input channel
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [AXIS_W-1:0] in_accel_x,
  input  logic signed [AXIS_W-1:0] in_accel_y,
  input  logic signed [AXIS_W-1:0] in_accel_z,
  // Result channel
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_inactivity_detected,
  output logic [MAG_W-1:0]         out_magnitude,
  // Configuration channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  ctl_state_t          state_r, state_nxt;
  logic [THR_W-1:0]    quiet_thr_r;
  logic [PERIOD_W-1:0] period_r;
  logic [QUIET_W-1:0]  inact_lim_r;
  logic [BUSY_W-1:0]   act_lim_r;
  logic [MAG_W-1:0]    seed_r;
  logic [MAG_W-1:0]    prev_mag_r;
  logic [QUIET_W-1:0]  quiet_time_r;
  logic [BUSY_W-1:0]   busy_time_r;
  logic                out_valid_r;
  logic                out_flag_r;
  logic [MAG_W-1:0]    out_mag_r;

  logic                in_take, start, mag_done, commit;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W:0]      diff_raw;
  logic [MAG_W-1:0]    diff;
  logic                quiet;
  logic [QUIET_W:0]    quiet_sum;
  logic [BUSY_W:0]     busy_sum;
  logic [QUIET_W-1:0]  quiet_sat;
  logic [BUSY_W-1:0]   busy_sat;
  logic                flag;
  logic [QUIET_W-1:0]  quiet_nxt;
  logic [BUSY_W-1:0]   busy_nxt;

  aid_mag u_mag (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .accel_x (in_accel_x),
    .accel_y (in_accel_y),
    .accel_z (in_accel_z),
    .done    (mag_done),
    .mag     (mag)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CALC;
      ST_CALC:   if (mag_done) state_nxt = ST_UPDATE;
      ST_UPDATE: if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    in_take   = in_valid && in_ready;
    start     = in_take;
    commit    = (state_r == ST_UPDATE) && (!out_valid_r || out_ready);
    cfg_ready = 1'b1;
  end

  // Compare with the previous magnitude and advance the time counts
  always_comb begin
    diff_raw  = {1'b0, mag} - {1'b0, prev_mag_r};
    diff      = diff_raw[MAG_W] ? MAG_W'(prev_mag_r - mag) : diff_raw[MAG_W-1:0];
    quiet     = (diff < quiet_thr_r);
    quiet_sum = {1'b0, quiet_time_r} + (QUIET_W+1)'(period_r);
    busy_sum  = {1'b0, busy_time_r} + (BUSY_W+1)'(period_r);
    quiet_sat = quiet_sum[QUIET_W] ? QUIET_MAX : quiet_sum[QUIET_W-1:0];
    busy_sat  = busy_sum[BUSY_W] ? BUSY_MAX : busy_sum[BUSY_W-1:0];
    flag      = 1'b0;
    quiet_nxt = quiet_time_r;
    busy_nxt  = busy_time_r;
    if (quiet) begin
      if (quiet_sat > inact_lim_r) begin
        flag      = 1'b1;
        quiet_nxt = '0;
        busy_nxt  = '0;
      end else begin
        quiet_nxt = quiet_sat;
      end
    end else begin
      if (busy_sat > act_lim_r) begin
        quiet_nxt = '0;
        busy_nxt  = '0;
      end else begin
        busy_nxt = busy_sat;
      end
    end
  end

  // Sequencer, tracking state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      prev_mag_r   <= SEED_RST;
      quiet_time_r <= '0;
      busy_time_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        out_valid_r  <= 1'b1;
        quiet_time_r <= quiet_nxt;
        busy_time_r  <= busy_nxt;
        prev_mag_r   <= flag ? seed_r : mag;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (commit) begin
      out_flag_r <= flag;
      out_mag_r  <= mag;
    end
  end

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_thr_r <= QUIET_THR_RST;
      period_r    <= PERIOD_RST;
      inact_lim_r <= INACT_LIM_RST;
      act_lim_r   <= ACT_LIM_RST;
      seed_r      <= SEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_QUIET_THR: quiet_thr_r <= cfg_data[THR_W-1:0];
        CFG_PERIOD:    period_r    <= cfg_data[PERIOD_W-1:0];
        CFG_INACT_LIM: inact_lim_r <= cfg_data[QUIET_W-1:0];
        CFG_ACT_LIM:   act_lim_r   <= cfg_data[BUSY_W-1:0];
        CFG_SEED:      seed_r      <= cfg_data[MAG_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_valid               = out_valid_r;
  assign out_inactivity_detected = out_flag_r;
  assign out_magnitude           = out_mag_r;

endmodule

[design/aid_mag.sv]
// Magnitude unit: bit-serial sum of squares, then digit-by-digit square root.
// Depends on aid_pkg.
module aid_mag
  import aid_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [AXIS_W-1:0] accel_x,
  input  logic signed [AXIS_W-1:0] accel_y,
  input  logic signed [AXIS_W-1:0] accel_z,
  output logic                     done,
  output logic [MAG_W-1:0]         mag
);

  localparam logic [CNT_W-1:0] LAST = '1;
  localparam int REM_W = MAG_W + 3;

  mag_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [AXIS_W-1:0]  mx_r, my_r, mz_r;
  logic [AXIS_W-1:0]  sx_r, sy_r, sz_r;
  logic [SUM_W-1:0]   sum_r;
  logic [REM_W-3:0]   rem_r;
  logic [MAG_W-1:0]   root_r;
  logic               done_r;
  logic               sq_en, root_en;

  logic [AXIS_W-1:0]  abs_x, abs_y, abs_z;
  logic [SUM_W-1:0]   sum_nxt;
  logic [REM_W-1:0]   rem_w, trial;

  // Take absolute values; the most negative sample maps to 0x8000
  always_comb begin
    abs_x = accel_x[AXIS_W-1] ? AXIS_W'(-accel_x) : AXIS_W'(accel_x);
    abs_y = accel_y[AXIS_W-1] ? AXIS_W'(-accel_y) : AXIS_W'(accel_y);
    abs_z = accel_z[AXIS_W-1] ? AXIS_W'(-accel_z) : AXIS_W'(accel_z);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      MG_IDLE:   if (start) state_nxt = MG_SQUARE;
      MG_SQUARE: if (cnt_r == LAST) state_nxt = MG_ROOT;
      MG_ROOT:   if (cnt_r == LAST) state_nxt = MG_IDLE;
      default:   state_nxt = MG_IDLE;
    endcase
  end

  // Step enables
  always_comb begin
    sq_en   = (state_r == MG_SQUARE);
    root_en = (state_r == MG_ROOT);
  end

  // Multiply MSB first: double the sum and add the selected multiplicands
  always_comb begin
    sum_nxt = {sum_r[SUM_W-2:0], 1'b0}
            + SUM_W'(mx_r & {AXIS_W{sx_r[AXIS_W-1]}})
            + SUM_W'(my_r & {AXIS_W{sy_r[AXIS_W-1]}})
            + SUM_W'(mz_r & {AXIS_W{sz_r[AXIS_W-1]}});
  end

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_w = {rem_r, sum_r[SUM_W-1:SUM_W-2]};
    trial = {1'b0, root_r, 2'b01};
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MG_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= root_en && (cnt_r == LAST);
      if (state_r != state_nxt) cnt_r <= '0;
      else if (sq_en || root_en) cnt_r <= cnt_r + 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start && (state_r == MG_IDLE)) begin
      mx_r  <= abs_x;
      my_r  <= abs_y;
      mz_r  <= abs_z;
      sx_r  <= abs_x;
      sy_r  <= abs_y;
      sz_r  <= abs_z;
      sum_r <= '0;
    end else if (sq_en) begin
      sum_r <= sum_nxt;
      sx_r  <= {sx_r[AXIS_W-2:0], 1'b0};
      sy_r  <= {sy_r[AXIS_W-2:0], 1'b0};
      sz_r  <= {sz_r[AXIS_W-2:0], 1'b0};
      if (cnt_r == LAST) begin
        rem_r  <= '0;
        root_r <= '0;
      end
    end else if (root_en) begin
      sum_r <= {sum_r[SUM_W-3:0], 2'b00};
      if (rem_w >= trial) begin
        rem_r  <= (REM_W-2)'(rem_w - trial);
        root_r <= {root_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_w[REM_W-3:0];
        root_r <= {root_r[MAG_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign mag  = root_r;

endmodule

[verif/tb_accel_inactivity_detector.sv]
// Self-checking testbench for accel_inactivity_detector: directed corner samples, then
// random sample streams under several register settings and flow-control mixes.
// Depends on aid_pkg and the detector RTL; expected results are computed in-line.
module tb_accel_inactivity_detector;
  timeunit 1ns;
  timeprecision 1ps;
  import aid_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int PERIOD_TOP = (1 << PERIOD_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_SEED + 1;
  localparam logic signed [AXIS_W-1:0] AXIS_LO = {1'b1, {(AXIS_W-1){1'b0}}};
  localparam logic signed [AXIS_W-1:0] AXIS_HI = {1'b0, {(AXIS_W-1){1'b1}}};

  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
  } accel_sample_t;

  typedef struct packed {
    logic             detected;
    logic [MAG_W-1:0] magnitude;
  } inact_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [AXIS_W-1:0] in_accel_x = '0;
  logic signed [AXIS_W-1:0] in_accel_y = '0;
  logic signed [AXIS_W-1:0] in_accel_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_inactivity_detected;
  logic [MAG_W-1:0] out_magnitude;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Pending samples and expected results
  accel_sample_t sample_q[$];
  inact_result_t result_q[$];
  accel_sample_t drive_sample;
  inact_result_t want;

  // Register copies and detector state as the predictor sees them
  logic [THR_W-1:0]    thr_reg;
  logic [PERIOD_W-1:0] period_reg;
  logic [QUIET_W-1:0]  inact_lim_reg;
  logic [BUSY_W-1:0]   act_lim_reg;
  logic [MAG_W-1:0]    seed_reg;
  logic [MAG_W-1:0]    prev_mag;
  logic [QUIET_W-1:0]  quiet_ms;
  logic [BUSY_W-1:0]   busy_ms;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int steady_noise = 0;
  int base_x, base_y, base_z;
  int error_count = 0;
  int sample_total = 0;
  int result_total = 0;
  int flag_total = 0;
  int config_total = 0;
  int cycle_count = 0;

  accel_inactivity_detector dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_accel_x              (in_accel_x),
    .in_accel_y              (in_accel_y),
    .in_accel_z              (in_accel_z),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_inactivity_detected (out_inactivity_detected),
    .out_magnitude           (out_magnitude),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Floor square root, one result bit per step from the top
  function automatic logic [MAG_W-1:0] floor_root(input logic [SUM_W-1:0] n);
    logic [MAG_W-1:0] root;
    logic [MAG_W-1:0] trial;
    root = '0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (MAG_W'(1) << b);
      if (SUM_W'(trial) * SUM_W'(trial) <= n) root = trial;
    end
    return root;
  endfunction

  function automatic logic [SUM_W-1:0] axis_square(input logic signed [AXIS_W-1:0] v);
    logic signed [AXIS_W:0] w;
    w = v;
    if (w < 0) w = -w;
    return SUM_W'(w) * SUM_W'(w);
  endfunction

  // Advance the detector state by one sample and queue the result it gives
  task automatic predict_sample(input logic signed [AXIS_W-1:0] x, y, z);
    logic [SUM_W-1:0]   sum;
    logic [MAG_W-1:0]   mag;
    logic [MAG_W-1:0]   delta;
    logic [QUIET_W:0]   qsum;
    logic [BUSY_W:0]    bsum;
    logic               detect;
    inact_result_t      res;
    sum = axis_square(x) + axis_square(y) + axis_square(z);
    mag = floor_root(sum);
    delta = (mag >= prev_mag) ? mag - prev_mag : prev_mag - mag;
    detect = 1'b0;
    if (delta < thr_reg) begin
      qsum = quiet_ms + period_reg;
      quiet_ms = (qsum > QUIET_MAX) ? QUIET_MAX : qsum[QUIET_W-1:0];
      detect = (quiet_ms > inact_lim_reg);
    end else begin
      bsum = busy_ms + period_reg;
      busy_ms = (bsum > BUSY_MAX) ? BUSY_MAX : bsum[BUSY_W-1:0];
      if (busy_ms > act_lim_reg) begin
        busy_ms = '0;
        quiet_ms = '0;
      end
    end
    if (detect) begin
      quiet_ms = '0;
      busy_ms = '0;
      prev_mag = seed_reg;
      flag_total++;
    end else begin
      prev_mag = mag;
    end
    res.detected = detect;
    res.magnitude = mag;
    result_q.push_back(res);
    sample_total++;
  endtask

  task automatic note_error(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  // Drive samples from the pending queue; predict each one at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_sample(in_accel_x, in_accel_y, in_accel_z);
      end
      if (!in_valid || in_ready) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drive_sample = sample_q.pop_front();
          in_valid <= 1'b1;
          in_accel_x <= drive_sample.x;
          in_accel_y <= drive_sample.y;
          in_accel_z <= drive_sample.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          note_error($sformatf("unexpected result: inactivity %0b magnitude %0d",
                               out_inactivity_detected, out_magnitude));
        end else begin
          want = result_q.pop_front();
          if (out_magnitude !== want.magnitude)
            note_error($sformatf("result %0d magnitude: expected %0d, got %0d",
                                 result_total, want.magnitude, out_magnitude));
          if (out_inactivity_detected !== want.detected)
            note_error($sformatf("result %0d inactivity: expected %0b, got %0b",
                                 result_total, want.detected, out_inactivity_detected));
        end
        result_total++;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, result_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Write one register and keep the predictor's copy in step
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_QUIET_THR: thr_reg = val[THR_W-1:0];
      CFG_PERIOD:    period_reg = val[PERIOD_W-1:0];
      CFG_INACT_LIM: inact_lim_reg = val[QUIET_W-1:0];
      CFG_ACT_LIM:   act_lim_reg = val[BUSY_W-1:0];
      CFG_SEED:      seed_reg = val[MAG_W-1:0];
      default: ;
    endcase
  endtask

  // Write all registers; unused upper data bits carry noise
  task automatic set_config(input int thr, period, inact, act, seed);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    write_reg(CFG_QUIET_THR, CFG_DATA_W'(thr));
    write_reg(CFG_PERIOD, {junk[CFG_DATA_W-1:PERIOD_W], PERIOD_W'(period)});
    write_reg(CFG_INACT_LIM, CFG_DATA_W'(inact));
    write_reg(CFG_ACT_LIM, {junk[CFG_DATA_W-1:BUSY_W], BUSY_W'(act)});
    write_reg(CFG_SEED, CFG_DATA_W'(seed));
    if ($urandom_range(0, 1) == 1)
      write_reg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(0, (1 << CFG_IDX_W) - 1 - CFG_SPARE_LO)),
                CFG_DATA_W'($urandom));
    config_total++;
  endtask

  // Limits a few samples long so detections and busy clears happen often
  task automatic set_moderate_config();
    int p;
    int thr;
    p = $urandom_range(1, PERIOD_TOP);
    thr = $urandom_range(50, 3000);
    steady_noise = thr / 4;
    set_config(thr, p, p * $urandom_range(2, 20), p * $urandom_range(1, 10),
               $urandom_range(0, 56755));
  endtask

  // Hold until the sender is empty and every expected result has arrived
  task automatic wait_idle();
    do @(posedge clk); while (sample_q.size() != 0 || in_valid || result_q.size() != 0);
  endtask

  task automatic queue_sample(input int x, y, z);
    accel_sample_t s;
    s.x = AXIS_W'(x);
    s.y = AXIS_W'(y);
    s.z = AXIS_W'(z);
    sample_q.push_back(s);
  endtask

  function automatic int jitter(input int centre);
    int v;
    v = centre + int'($urandom_range(0, 2 * steady_noise)) - steady_noise;
    if (v < int'(AXIS_LO)) v = int'(AXIS_LO);
    if (v > int'(AXIS_HI)) v = int'(AXIS_HI);
    return v;
  endfunction

  function automatic int extreme_axis();
    case ($urandom_range(0, 4))
      0: return int'(AXIS_LO);
      1: return int'(AXIS_HI);
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // Pick a resting vector, half the time built from the seed magnitude
  task automatic pick_base();
    int s;
    s = seed_reg;
    if ($urandom_range(0, 1) == 1) begin
      if (s <= int'(AXIS_HI)) begin
        base_x = 0;
        base_y = 0;
        base_z = -s;
      end else begin
        base_x = s * 7 / 10;
        base_y = -(s * 7 / 10);
        base_z = 0;
      end
    end else begin
      base_x = int'($urandom_range(0, 40000)) - 20000;
      base_y = int'($urandom_range(0, 40000)) - 20000;
      base_z = int'($urandom_range(0, 40000)) - 20000;
    end
  endtask

  // Mostly quiet runs around a resting vector, with jolts and corner values
  task automatic queue_mixed(input int count);
    int pick;
    pick_base();
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) pick_base();
      if (pick < 70)
        queue_sample(jitter(base_x), jitter(base_y), jitter(base_z));
      else if (pick < 88)
        queue_sample($urandom, $urandom, $urandom);
      else
        queue_sample(extreme_axis(), extreme_axis(), extreme_axis());
    end
  endtask

  initial begin
    thr_reg = QUIET_THR_RST;
    period_reg = PERIOD_RST;
    inact_lim_reg = INACT_LIM_RST;
    act_lim_reg = ACT_LIM_RST;
    seed_reg = SEED_RST;
    prev_mag = SEED_RST;
    quiet_ms = '0;
    busy_ms = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Axis extremes under the reset settings
    queue_sample(0, 0, 0);
    queue_sample(-32768, -32768, -32768);
    queue_sample(32767, 32767, 32767);
    queue_sample(-32768, 0, 0);
    queue_sample(0, 32767, 0);
    queue_sample(0, 0, -32768);
    queue_sample(-1, -1, -1);
    queue_sample(1, 0, 0);
    queue_sample(8234, 0, 0);
    wait_idle();

    // Zero sample period adds nothing; spare register index is ignored
    set_config(100, 0, 1000, 1000, SEED_RST);
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    queue_sample(8200, 0, 0);
    queue_sample(0, -8210, 0);
    queue_sample(20000, 0, 0);
    wait_idle();

    // Zero limits: detect on first quiet sample, reseed the previous magnitude
    set_config(500, PERIOD_TOP, 0, 0, 1000);
    queue_sample(300, 400, 0);
    queue_sample(0, 0, 600);
    queue_sample(0, 1000, 0);
    wait_idle();
    // New seed applies only from the next detection on
    write_reg(CFG_SEED, 2000);
    queue_sample(0, 0, 1000);
    queue_sample(-2000, 0, 0);
    queue_sample(0, 2000, 0);
    wait_idle();

    // No idling, moderate limits
    set_moderate_config();
    queue_mixed(130);
    wait_idle();

    // Sender mostly idle; everything quiet so the quiet time saturates
    send_idle_pct = 62;
    steady_noise = 500;
    set_config(int'(QUIET_MAX), PERIOD_TOP, int'(QUIET_MAX), $urandom_range(0, 10000),
               $urandom_range(0, 56755));
    queue_mixed(270);
    wait_idle();

    // Receiver mostly stalled; nothing quiet so the busy time saturates
    send_idle_pct = 0;
    recv_stall_pct = 62;
    set_config(0, PERIOD_TOP, $urandom_range(0, 60000), int'(BUSY_MAX),
               $urandom_range(0, 56755));
    queue_mixed(90);
    wait_idle();

    // Both sides idle a quarter of the time, with a full drain midway
    send_idle_pct = 25;
    recv_stall_pct = 25;
    set_moderate_config();
    queue_mixed(65);
    wait_idle();
    queue_mixed(65);
    wait_idle();

    // Minimum settings: only exact repeats are quiet, every quiet sample detects
    send_idle_pct = 0;
    recv_stall_pct = 0;
    steady_noise = 0;
    set_config(1, 1, 0, 0, 0);
    queue_mixed(60);
    wait_idle();

    // Sender idle again with fresh moderate limits
    send_idle_pct = 62;
    set_moderate_config();
    queue_mixed(70);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results for %0d samples across %0d register settings,",
             result_total, sample_total, config_total);
    $display("%0d inactivity detections; saturation, zero-limit and stall mixes exercised.",
             flag_total);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
